// ===== src/rpc_pkg.sv =====
// Shared types, codes and preset colour tables for the RGB preset crossfade.
// No dependencies; all files but the interfaces and checker import it.
package rpc_pkg;

  localparam int CHANNELS          = 6;
  localparam int TABLE_SLOTS       = 16;
  localparam int FADE_STEPS_DEF    = 60;
  localparam int ROOM_PRESETS_DEF  = 6;
  localparam int FLOOR_PRESETS_DEF = 4;

  typedef logic [2:0]  ch_t;
  typedef logic [3:0]  preset_idx_t;
  typedef logic [14:0] color_t;
  typedef logic [4:0]  comp_t;

  // channel order: light 0, light 1, diffuse, ambient, specular, emission
  localparam ch_t CH_LIGHT0 = 3'd0;
  localparam ch_t CH_LIGHT1 = 3'd1;
  localparam ch_t CH_LAST   = 3'(CHANNELS - 1);

  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_ROOM  = 2'd2,
    KIND_FLOOR = 2'd3
  } kind_t;

  // one channel walk step handed from the sequencer to the pipeline
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    ch_t         ch;
    preset_idx_t room;
    preset_idx_t floor;
  } issue_t;

  typedef struct packed {
    color_t cur;
    color_t start;
    color_t tgt;
  } color_set_t;

  typedef struct packed {
    logic       valid;
    ch_t        ch;
    color_set_t colors;
  } wr_t;

  // red in bits 4:0, green 9:5, blue 14:10
  function automatic color_t rgb(comp_t r, comp_t g, comp_t b);
    return {b, g, r};
  endfunction

  // slot 0 light 0, slot 1 diffuse, 2 ambient, 3 specular, 4 emission
  function automatic color_t room_color(preset_idx_t idx, logic [2:0] slot);
    color_t light;
    color_t amb;
    color_t emi;
    color_t res;
    light = '0;
    amb   = rgb(5'd14, 5'd14, 5'd14);
    emi   = rgb(5'd16, 5'd16, 5'd16);
    case (idx)
      4'd0: light = rgb(5'd23, 5'd23, 5'd25);
      4'd1: light = rgb(5'd10, 5'd10, 5'd16);
      4'd2: light = rgb(5'd8, 5'd8, 5'd12);
      4'd3: begin
        light = rgb(5'd5, 5'd5, 5'd8);
        amb   = rgb(5'd13, 5'd13, 5'd14);
      end
      4'd4: begin
        light = rgb(5'd3, 5'd3, 5'd7);
        amb   = rgb(5'd10, 5'd10, 5'd12);
        emi   = rgb(5'd14, 5'd14, 5'd16);
      end
      4'd5: begin
        light = rgb(5'd0, 5'd0, 5'd6);
        amb   = rgb(5'd8, 5'd8, 5'd10);
        emi   = rgb(5'd12, 5'd12, 5'd16);
      end
      default: light = '0;
    endcase
    case (slot)
      3'd0:    res = light;
      3'd1:    res = rgb(5'd16, 5'd16, 5'd16);
      3'd2:    res = amb;
      3'd3:    res = rgb(5'd20, 5'd20, 5'd20);
      3'd4:    res = emi;
      default: res = '0;
    endcase
    // presets past the listed ones are black
    if (idx > 4'd5) begin
      res = '0;
    end
    return res;
  endfunction

  function automatic color_t floor_color(preset_idx_t idx);
    color_t res;
    case (idx)
      4'd0:    res = rgb(5'd14, 5'd14, 5'd14);
      4'd1:    res = rgb(5'd20, 5'd20, 5'd20);
      4'd2:    res = rgb(5'd31, 5'd31, 5'd31);
      4'd3:    res = rgb(5'd8, 5'd8, 5'd8);
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic color_t preset_color(ch_t ch, preset_idx_t room, preset_idx_t floor);
    color_t res;
    if (ch == CH_LIGHT1) begin
      res = floor_color(floor);
    end else if (ch == CH_LIGHT0) begin
      res = room_color(room, 3'd0);
    end else begin
      res = room_color(room, 3'(ch - 3'd1));
    end
    return res;
  endfunction

endpackage

// ===== src/rpc_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one input item.
// Depends on nothing.
interface rpc_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] room_preset;
  logic [1:0] floor_preset;

  modport source (output valid, kind, room_preset, floor_preset, input ready);
  modport sink   (input valid, kind, room_preset, floor_preset, output ready);
endinterface

// ===== src/rpc_colors_if.sv =====
// Result channel: valid/ready handshake carrying all six RGB555 colours.
// Depends on nothing.
interface rpc_colors_if;
  logic        valid;
  logic        ready;
  logic [14:0] light0_color;
  logic [14:0] light1_color;
  logic [14:0] diffuse_color;
  logic [14:0] ambient_color;
  logic [14:0] specular_color;
  logic [14:0] emission_color;

  modport source (output valid, light0_color, light1_color, diffuse_color, ambient_color,
                  specular_color, emission_color, input ready);
  modport sink   (input valid, light0_color, light1_color, diffuse_color, ambient_color,
                  specular_color, emission_color, output ready);
endinterface

// ===== src/rpc_seq.sv =====
// Item sequencer: takes command items and walks the six channels, one a cycle
// unless stalled. Depends on rpc_pkg and rpc_cmd_if.
module rpc_seq
  import rpc_pkg::*;
#(
  parameter int ROOM_PRESETS  = ROOM_PRESETS_DEF,
  parameter int FLOOR_PRESETS = FLOOR_PRESETS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rpc_cmd_if.sink    cmd,
  input  logic       stall,
  output issue_t     issue
);

  logic        busy;
  ch_t         ch;
  kind_t       kind;
  preset_idx_t room;
  preset_idx_t floor;
  logic        accept;
  preset_idx_t room_sat;
  preset_idx_t floor_sat;

  // take the next item as the last channel of this one goes out
  assign cmd.ready = (!busy || ch == CH_LAST) && !stall;
  assign accept    = cmd.valid && cmd.ready;

  // saturate out-of-range indices to the last preset
  assign room_sat  = (int'(cmd.room_preset) >= ROOM_PRESETS) ?
                     preset_idx_t'(ROOM_PRESETS - 1) : preset_idx_t'(cmd.room_preset);
  assign floor_sat = (int'(cmd.floor_preset) >= FLOOR_PRESETS) ?
                     preset_idx_t'(FLOOR_PRESETS - 1) : preset_idx_t'(cmd.floor_preset);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ch   <= CH_LIGHT0;
    end else if (!stall) begin
      if (accept) begin
        busy <= 1'b1;
        ch   <= CH_LIGHT0;
      end else if (busy) begin
        if (ch == CH_LAST) begin
          busy <= 1'b0;
        end else begin
          ch <= ch + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind  <= kind_t'(cmd.kind);
      room  <= room_sat;
      floor <= floor_sat;
    end
  end

  always_comb begin
    issue.valid = busy;
    issue.kind  = kind;
    issue.ch    = ch;
    issue.room  = room;
    issue.floor = floor;
  end

endmodule

// ===== src/rpc_mem.sv =====
// Channel state memory: colours and fade counters, one entry per channel.
// Synchronous read. Depends on rpc_pkg.
module rpc_mem
  import rpc_pkg::*;
#(
  parameter  int FADE_STEPS = FADE_STEPS_DEF,
  localparam int CntW       = $clog2(FADE_STEPS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            stall,
  input  ch_t             rd_ch,
  output color_set_t      rd_colors,
  output logic [CntW-1:0] rd_cnt,
  input  wr_t             wr,
  input  logic [CntW-1:0] wr_cnt
);

  color_set_t            color_mem [CHANNELS];
  logic [CntW-1:0]       cnt_mem   [CHANNELS];
  logic [CHANNELS-1:0]   written;
  color_set_t            rd_colors_q;
  logic [CntW-1:0]       rd_cnt_q;
  logic                  rd_written;

  // writes come from the last stage, behind the read, so the two never meet
  always_ff @(posedge clk) begin
    if (!stall) begin
      rd_colors_q <= color_mem[rd_ch];
      rd_cnt_q    <= cnt_mem[rd_ch];
      rd_written  <= written[rd_ch];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.valid && !stall) begin
      color_mem[wr.ch] <= wr.colors;
      cnt_mem[wr.ch]   <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.valid && !stall) begin
      written[wr.ch] <= 1'b1;
    end
  end

  // an entry not yet written reads as black with its fade finished
  assign rd_colors = rd_written ? rd_colors_q : '0;
  assign rd_cnt    = rd_written ? rd_cnt_q : CntW'(FADE_STEPS);

endmodule

// ===== src/rpc_fade_pipe.sv =====
// Read-modify-write pipeline: blends each channel, writes it back, and
// gathers the six colours into the result register. Depends on rpc_pkg.
module rpc_fade_pipe
  import rpc_pkg::*;
#(
  parameter  int FADE_STEPS = FADE_STEPS_DEF,
  localparam int CntW       = $clog2(FADE_STEPS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  issue_t          issue,
  input  color_set_t      rd_colors,
  input  logic [CntW-1:0] rd_cnt,
  output logic            stall,
  output wr_t             wr,
  output logic [CntW-1:0] wr_cnt,
  rpc_colors_if.source    colors
);

  localparam int PW    = CntW + 5;
  localparam int Sh    = PW + $clog2(FADE_STEPS);
  localparam int RecW  = Sh + 1;
  localparam int ProdW = PW + RecW;
  localparam logic [RecW-1:0] Recip = RecW'((2 ** Sh + FADE_STEPS - 1) / FADE_STEPS);

  // stage 1: entry from memory
  logic            s1_valid;
  issue_t          s1_ctl;
  color_t          s1_preset;
  logic            s1_active;
  logic [CntW-1:0] s1_cnt_inc;
  logic [2:0]      s1_neg;
  logic [PW-1:0]   s1_p [3];

  // stage 2: products
  logic            s2_valid;
  issue_t          s2_ctl;
  color_set_t      s2_col;
  logic [CntW-1:0] s2_cnt;
  logic            s2_active;
  color_t          s2_preset;
  logic [2:0]      s2_neg;
  logic [PW-1:0]   s2_p [3];
  logic [ProdW-1:0] s2_prod [3];

  // stage 3: quotients, write back
  logic            s3_valid;
  issue_t          s3_ctl;
  color_set_t      s3_col;
  logic [CntW-1:0] s3_cnt;
  logic            s3_active;
  color_t          s3_preset;
  logic [2:0]      s3_neg;
  comp_t           s3_q [3];
  color_t          s3_blend;
  color_set_t      new_col;
  logic [CntW-1:0] new_cnt;
  logic            moved;
  logic            moved_acc;
  logic            moved_any;
  logic            emit;
  logic            load;

  color_t          collect [CHANNELS];
  logic            res_valid;
  color_t          res_color [CHANNELS];

  always_comb begin
    comp_t s;
    comp_t t;
    s1_preset  = preset_color(s1_ctl.ch, s1_ctl.room, s1_ctl.floor);
    s1_active  = rd_cnt < CntW'(FADE_STEPS);
    s1_cnt_inc = rd_cnt + CntW'(1);
    for (int k = 0; k < 3; k++) begin
      s = rd_colors.start[5*k +: 5];
      t = rd_colors.tgt[5*k +: 5];
      s1_neg[k] = t < s;
      s1_p[k]   = PW'(s1_cnt_inc) * PW'(s1_neg[k] ? s - t : t - s);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s2_prod[k] = ProdW'(s2_p[k]) * ProdW'(Recip);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= issue.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_ctl    <= issue;
      s2_ctl    <= s1_ctl;
      s2_col    <= rd_colors;
      s2_cnt    <= rd_cnt;
      s2_active <= s1_active;
      s2_preset <= s1_preset;
      s2_neg    <= s1_neg;
      s3_ctl    <= s2_ctl;
      s3_col    <= s2_col;
      s3_cnt    <= s2_cnt;
      s3_active <= s2_active;
      s3_preset <= s2_preset;
      s3_neg    <= s2_neg;
      for (int k = 0; k < 3; k++) begin
        s2_p[k] <= s1_p[k];
        s3_q[k] <= s2_prod[k][Sh +: 5];
      end
    end
  end

  // quotient truncates toward zero, so apply the sign after dividing
  always_comb begin
    comp_t s;
    for (int k = 0; k < 3; k++) begin
      s = s3_col.start[5*k +: 5];
      s3_blend[5*k +: 5] = s3_neg[k] ? s - s3_q[k] : s + s3_q[k];
    end
  end

  always_comb begin
    new_col = s3_col;
    new_cnt = s3_cnt;
    moved   = 1'b0;
    unique case (s3_ctl.kind)
      KIND_INIT: begin
        new_col.cur   = s3_preset;
        new_col.start = '0;
        new_col.tgt   = '0;
        new_cnt       = CntW'(FADE_STEPS);
      end
      KIND_TICK: begin
        if (s3_active) begin
          new_col.cur = s3_blend;
          new_cnt     = s3_cnt + CntW'(1);
          moved       = 1'b1;
        end
      end
      KIND_ROOM: begin
        if (s3_ctl.ch != CH_LIGHT1) begin
          new_col.start = s3_col.cur;
          new_col.tgt   = s3_preset;
          new_cnt       = '0;
        end
      end
      KIND_FLOOR: begin
        if (s3_ctl.ch == CH_LIGHT1) begin
          new_col.start = s3_col.cur;
          new_col.tgt   = s3_preset;
          new_cnt       = '0;
        end
      end
    endcase
  end

  assign moved_any = ((s3_ctl.ch == CH_LIGHT0) ? 1'b0 : moved_acc) | moved;
  assign emit      = (s3_ctl.kind == KIND_INIT) || (s3_ctl.kind == KIND_TICK && moved_any);
  assign load      = s3_valid && s3_ctl.ch == CH_LAST && emit;
  // hold the whole pipe only when a finished item meets a full result register
  assign stall     = load && res_valid && !colors.ready;

  always_comb begin
    wr.valid  = s3_valid;
    wr.ch     = s3_ctl.ch;
    wr.colors = new_col;
    wr_cnt    = new_cnt;
  end

  always_ff @(posedge clk) begin
    if (s3_valid && !stall) begin
      moved_acc          <= moved_any;
      collect[s3_ctl.ch] <= new_col.cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load && !stall) begin
      res_valid <= 1'b1;
    end else if (colors.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !stall) begin
      for (int i = 0; i < CHANNELS - 1; i++) begin
        res_color[i] <= collect[i];
      end
      res_color[CHANNELS-1] <= new_col.cur;
    end
  end

  assign colors.valid          = res_valid;
  assign colors.light0_color   = res_color[0];
  assign colors.light1_color   = res_color[1];
  assign colors.diffuse_color  = res_color[2];
  assign colors.ambient_color  = res_color[3];
  assign colors.specular_color = res_color[4];
  assign colors.emission_color = res_color[5];

endmodule

// ===== src/rgb_preset_crossfade_core.sv =====
// Linear colour crossfade over six RGB555 channels held in a state memory.
// Channels pass the memory read, product and quotient stages, then the result register.
// One channel per cycle uses the state memory port unless stalled; successive items overlap.
// Reset (synchronous): clears control and the per-entry written flags, so every channel
// reads as black with its fade finished; there is no clearing pass.
// Depends on rpc_pkg, rpc_cmd_if, rpc_colors_if, rpc_seq, rpc_mem and rpc_fade_pipe.
module rgb_preset_crossfade_core
  import rpc_pkg::*;
#(
  parameter int FADE_STEPS    = FADE_STEPS_DEF,
  parameter int ROOM_PRESETS  = ROOM_PRESETS_DEF,
  parameter int FLOOR_PRESETS = FLOOR_PRESETS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  rpc_cmd_if.sink      cmd,
  rpc_colors_if.source colors
);

  localparam int CntW = $clog2(FADE_STEPS + 1);

  issue_t          issue;
  logic            stall;
  color_set_t      rd_colors;
  logic [CntW-1:0] rd_cnt;
  wr_t             wr;
  logic [CntW-1:0] wr_cnt;

  rpc_seq #(
    .ROOM_PRESETS  (ROOM_PRESETS),
    .FLOOR_PRESETS (FLOOR_PRESETS)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .stall (stall),
    .issue (issue)
  );

  rpc_mem #(
    .FADE_STEPS (FADE_STEPS)
  ) u_mem (
    .clk       (clk),
    .rst       (rst),
    .stall     (stall),
    .rd_ch     (issue.ch),
    .rd_colors (rd_colors),
    .rd_cnt    (rd_cnt),
    .wr        (wr),
    .wr_cnt    (wr_cnt)
  );

  rpc_fade_pipe #(
    .FADE_STEPS (FADE_STEPS)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .rd_colors (rd_colors),
    .rd_cnt    (rd_cnt),
    .stall     (stall),
    .wr        (wr),
    .wr_cnt    (wr_cnt),
    .colors    (colors)
  );

endmodule

// ===== src/rpc_checker.sv =====
// Port-level checks for the crossfade core, bound to the top level.
// Depends on rgb_preset_crossfade_core.
module rpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        colors_valid,
  input logic        colors_ready,
  input logic [89:0] colors_data
);

  logic cmd_accept;
  assign cmd_accept = cmd_valid && cmd_ready;

  // no result may survive a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !colors_valid)
    else $error("result valid after reset");

  // the walk keeps cmd_ready low until an item's last channel is issued
  a_walk_spacing: assert property (@(posedge clk) disable iff (rst)
    cmd_accept |=> !cmd_ready ##1 !cmd_ready ##1 !cmd_ready ##1 !cmd_ready ##1 !cmd_ready)
    else $error("item taken during channel walk");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    colors_valid && !colors_ready |=> colors_valid && $stable(colors_data))
    else $error("stalled result changed");

endmodule

bind rgb_preset_crossfade_core rpc_checker u_rpc_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .colors_valid (colors.valid),
  .colors_ready (colors.ready),
  .colors_data  ({colors.light0_color, colors.light1_color, colors.diffuse_color,
                  colors.ambient_color, colors.specular_color, colors.emission_color})
);

// ===== tb/rgb_preset_crossfade_core_test.sv =====
// Self-checking test of rgb_preset_crossfade_core: init snaps, room and floor fades, ticks.
// Predicts each colour set from its own fade state; needs rpc_pkg, interfaces and the core.
module rgb_preset_crossfade_core_test;
  import rpc_pkg::*;

  localparam int FADE         = 60;
  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_ITEMS = 1530;
  localparam int SETTLE       = 30;

  typedef logic [CHANNELS-1:0][14:0] palette_t;

  // colours packed as {blue, green, red}
  localparam color_t LIGHT0_TONE [6] = '{
    {5'd25, 5'd23, 5'd23}, {5'd16, 5'd10, 5'd10}, {5'd12, 5'd8, 5'd8},
    {5'd8, 5'd5, 5'd5},    {5'd7, 5'd3, 5'd3},    {5'd6, 5'd0, 5'd0}
  };
  localparam color_t AMBIENT_TONE [6] = '{
    {5'd14, 5'd14, 5'd14}, {5'd14, 5'd14, 5'd14}, {5'd14, 5'd14, 5'd14},
    {5'd14, 5'd13, 5'd13}, {5'd12, 5'd10, 5'd10}, {5'd10, 5'd8, 5'd8}
  };
  localparam color_t EMISSION_TONE [6] = '{
    {5'd16, 5'd16, 5'd16}, {5'd16, 5'd16, 5'd16}, {5'd16, 5'd16, 5'd16},
    {5'd16, 5'd16, 5'd16}, {5'd16, 5'd14, 5'd14}, {5'd16, 5'd12, 5'd12}
  };
  localparam color_t FLOOR_TONE [4] = '{
    {5'd14, 5'd14, 5'd14}, {5'd20, 5'd20, 5'd20}, {5'd31, 5'd31, 5'd31}, {5'd8, 5'd8, 5'd8}
  };
  localparam color_t DIFFUSE_TONE  = {5'd16, 5'd16, 5'd16};
  localparam color_t SPECULAR_TONE = {5'd20, 5'd20, 5'd20};

  localparam string CH_NAME [CHANNELS] = '{
    "light0", "light1", "diffuse", "ambient", "specular", "emission"
  };

  logic clk = 1'b0;
  logic rst;

  rpc_cmd_if    cmd_ch ();
  rpc_colors_if res_ch ();

  rgb_preset_crossfade_core u_top (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .colors (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // fade state mirrored per channel
  color_t   shade     [CHANNELS];
  color_t   fade_from [CHANNELS];
  color_t   fade_to   [CHANNELS];
  int       steps_done[CHANNELS];
  palette_t pending_palettes[$];

  int  errors       = 0;
  int  sent_count   = 0;
  int  colour_sets  = 0;
  int  idle_cycles  = 0;
  int  stall_left   = 0;
  int  kind_seen[4] = '{0, 0, 0, 0};
  bit  calm         = 1'b0;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // saturate the room index to the last preset
  function automatic color_t room_tone(logic [2:0] room, int ch);
    int r;
    r = (room > 3'd5) ? 5 : int'(room);
    case (ch)
      0:       return LIGHT0_TONE[r];
      2:       return DIFFUSE_TONE;
      3:       return AMBIENT_TONE[r];
      4:       return SPECULAR_TONE;
      default: return EMISSION_TONE[r];
    endcase
  endfunction

  function automatic color_t fade_point(color_t from, color_t to, int n);
    color_t res;
    int     s;
    int     t;
    int     v;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      s = from[5*k +: 5];
      t = to[5*k +: 5];
      v = s + (n * (t - s)) / FADE;
      res[5*k +: 5] = v[4:0];
    end
    return res;
  endfunction

  function automatic void reset_shades();
    for (int ch = 0; ch < CHANNELS; ch++) begin
      shade[ch]      = '0;
      fade_from[ch]  = '0;
      fade_to[ch]    = '0;
      steps_done[ch] = FADE;
    end
  endfunction

  function automatic void push_palette();
    palette_t p;
    for (int ch = 0; ch < CHANNELS; ch++) p[ch] = shade[ch];
    pending_palettes.push_back(p);
  endfunction

  function automatic void predict_palette(kind_t k, logic [2:0] room, logic [1:0] flr);
    bit moved;
    moved = 1'b0;
    case (k)
      KIND_INIT: begin
        reset_shades();
        for (int ch = 0; ch < CHANNELS; ch++) begin
          shade[ch] = (ch == 1) ? FLOOR_TONE[flr] : room_tone(room, ch);
        end
        push_palette();
      end
      KIND_TICK: begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          if (steps_done[ch] < FADE) begin
            steps_done[ch]++;
            shade[ch] = fade_point(fade_from[ch], fade_to[ch], steps_done[ch]);
            moved = 1'b1;
          end
        end
        if (moved) push_palette();
      end
      KIND_ROOM: begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          if (ch != 1) begin
            fade_from[ch]  = shade[ch];
            fade_to[ch]    = room_tone(room, ch);
            steps_done[ch] = 0;
          end
        end
      end
      default: begin
        fade_from[1]  = shade[1];
        fade_to[1]    = FLOOR_TONE[flr];
        steps_done[1] = 0;
      end
    endcase
  endfunction

  // predict on accepted items, check accepted colour sets, watch for a hang
  always @(posedge clk) begin
    palette_t got;
    palette_t want;
    if (!rst) begin
      idle_cycles++;
      if (cmd_ch.valid && cmd_ch.ready) begin
        idle_cycles = 0;
        kind_seen[cmd_ch.kind]++;
        predict_palette(kind_t'(cmd_ch.kind), cmd_ch.room_preset, cmd_ch.floor_preset);
      end
      if (res_ch.valid && res_ch.ready) begin
        idle_cycles = 0;
        colour_sets++;
        got = {res_ch.emission_color, res_ch.specular_color, res_ch.ambient_color,
               res_ch.diffuse_color, res_ch.light1_color, res_ch.light0_color};
        if (pending_palettes.size() == 0) begin
          errors++;
          $display("%0t: unexpected colour set, expected none, got %h", $time, got);
        end else begin
          want = pending_palettes.pop_front();
          for (int ch = 0; ch < CHANNELS; ch++) begin
            if (got[ch] !== want[ch]) begin
              errors++;
              $display("%0t: %s expected %h got %h", $time, CH_NAME[ch], want[ch], got[ch]);
            end
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d colour sets outstanding",
                 $time, idle_cycles, pending_palettes.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // valid stays high straight into the next item when there is no gap
  task automatic send_item(kind_t k, logic [2:0] room, logic [1:0] flr);
    int gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.kind         <= k;
    cmd_ch.room_preset  <= room;
    cmd_ch.floor_preset <= flr;
    do @(posedge clk); while (!cmd_ch.ready);
    sent_count++;
  endtask

  // hold the sender until every colour set predicted so far has come back
  task automatic wait_drained();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_palettes.size() != 0) @(posedge clk);
  endtask

  task automatic test_after_reset();
    send_item(KIND_TICK, 3'd0, 2'd0);   // all fades finished: nothing comes
    send_item(KIND_FLOOR, 3'd0, 2'd3);
    send_item(KIND_TICK, 3'd7, 2'd3);
    send_item(KIND_TICK, 3'd0, 2'd0);
    send_item(KIND_ROOM, 3'd7, 2'd0);   // index past the table saturates
    send_item(KIND_TICK, 3'd5, 2'd1);
    wait_drained();
  endtask

  task automatic test_init_snap();
    logic [2:0] room;
    for (int r = 0; r < 8; r++) begin
      room = 3'(r);
      send_item(KIND_INIT, room, room[1:0]);
    end
    send_item(KIND_ROOM, 3'd2, 2'd2);
    send_item(KIND_TICK, 3'd0, 2'd0);
    send_item(KIND_INIT, 3'd4, 2'd2);   // init drops a fade under way
    send_item(KIND_TICK, 3'd0, 2'd0);
    wait_drained();
  endtask

  task automatic test_random_mix();
    int target;
    int roll;
    int ticks;
    target = sent_count + RANDOM_ITEMS;
    while (sent_count < target) begin
      calm = ($urandom_range(0, 5) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 15) send_item(KIND_INIT, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
      if (roll < 80) begin
        case ($urandom_range(0, 2))
          0: send_item(KIND_ROOM, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
          1: send_item(KIND_FLOOR, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
          default: begin
            send_item(KIND_FLOOR, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
            send_item(KIND_ROOM, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
          end
        endcase
        // either a partial fade or one run near or past its end
        ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(55, 65) : $urandom_range(1, 30);
        repeat (ticks) send_item(KIND_TICK, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_item(kind_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                    2'($urandom_range(0, 3)));
        end
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    calm = 1'b0;
  endtask

  initial begin
    rst                 = 1'b1;
    cmd_ch.valid        = 1'b0;
    cmd_ch.kind         = KIND_INIT;
    cmd_ch.room_preset  = '0;
    cmd_ch.floor_preset = '0;
    reset_shades();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_init_snap();
    test_random_mix();

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d items: %0d init, %0d tick, %0d set room, %0d set floor.",
             sent_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("Checked %0d colour sets, %0d mismatches.", colour_sets, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
